// ----- design/mtg_pkg.sv -----
// ----------------------------------------------------------------------------
// mtg_pkg
// Constants and the output tempering function of the MT19937 word generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

   localparam int STATE_DEPTH  = 624;
   localparam int TWIST_OFFSET = 397;
   localparam int ADDR_W       = $clog2(STATE_DEPTH + 2);

   typedef logic [31:0]       word_type;
   typedef logic [ADDR_W-1:0] index_type;

   localparam index_type LAST_INDEX   = index_type'(STATE_DEPTH - 1);
   localparam index_type DEPTH_INDEX  = index_type'(STATE_DEPTH);
   localparam index_type UNSEEDED_POS = index_type'(STATE_DEPTH + 1);
   localparam index_type FAR_SPLIT    = index_type'(STATE_DEPTH - TWIST_OFFSET);
   localparam index_type FAR_FWD      = index_type'(TWIST_OFFSET);
   localparam index_type FAR_BACK     = index_type'(STATE_DEPTH - TWIST_OFFSET);

   localparam word_type TWIST_MATRIX = 32'h9908_b0df;
   localparam word_type SEED_MULT    = 32'd1812433253;
   localparam word_type TEMPER_B     = 32'h9d2c_5680;
   localparam word_type TEMPER_C     = 32'hefc6_0000;
   localparam word_type SEED_RESET   = 32'd5489;

   function automatic word_type temper(input word_type w);
      word_type y;
      y = w;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

// ----- design/mersenne_twister_generator.sv -----
// ----------------------------------------------------------------------------
// mersenne_twister_generator
// MT19937 generator: one tempered 32-bit word per request, state in a RAM.
// ----------------------------------------------------------------------------
// Each request returns one tempered word. A plain request reads the
// 624-word state RAM synchronously, then tempers the word and loads the
// output register. When the read position passes the end, a twist pass
// rewrites the state first: a priming read, then for each word two RAM
// reads and one write, then a read of the first new word. A request with
// restart set, or the first request after reset, seeds the state from the
// seed register before that: the seeding recurrence is a serial chain of a
// 32x32 multiply and an add per word, followed by the twist pass. The seed
// register is written through the csr port and takes effect on the next
// seeding; the user must write it only while the block is idle, as the
// block itself does not enforce this. A finished word waits in the output
// register while the next request is already being worked on.
module mersenne_twister_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] restart, [7:1] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] random_word
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [31:0] csr_tdata    // [31:0] seed_value
);
   import mtg_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED_MUL,
      ST_SEED_ADD,
      ST_TW_PRIME,
      ST_TW_RD,
      ST_TW_WR,
      ST_RD,
      ST_OUT
   } fsm_type;

   word_type  state_mem [STATE_DEPTH];
   word_type  rd_a_ff, rd_b_ff;

   fsm_type   state_ff;
   index_type pos_ff, k_ff;
   word_type  seed_ff, prev_ff, prod_ff, cur_ff;
   logic      rsp_valid_ff;
   word_type  rsp_data_ff;

   logic      req_accept, need_seed, out_free, rsp_load;
   index_type next_idx, far_idx, rd_a_addr, mem_waddr;
   logic      mem_we;
   word_type  mem_wdata, seed_word, twist_y, twist_word;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_tready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign req_accept = req_tvalid && req_tready;
   assign need_seed  = req_tdata[0] || (pos_ff > DEPTH_INDEX);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_load   = (state_ff == ST_OUT) && out_free;

   assign next_idx   = (k_ff == LAST_INDEX) ? '0 : k_ff + index_type'(1);
   assign far_idx    = (k_ff < FAR_SPLIT) ? k_ff + FAR_FWD : k_ff - FAR_BACK;

   assign seed_word  = prod_ff + word_type'(k_ff);
   assign twist_y    = {cur_ff[31], rd_a_ff[30:0]};
   assign twist_word = rd_b_ff ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MATRIX : '0);

   // RAM port steering
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = k_ff;
      mem_wdata = seed_word;
      rd_a_addr = pos_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && need_seed) begin
               mem_we    = 1'b1;
               mem_waddr = '0;
               mem_wdata = seed_ff;
            end
         end
         ST_SEED_ADD: begin
            mem_we = 1'b1;
         end
         ST_TW_PRIME: begin
            rd_a_addr = '0;
         end
         ST_TW_RD: begin
            rd_a_addr = next_idx;
         end
         ST_TW_WR: begin
            mem_we    = 1'b1;
            mem_wdata = twist_word;
         end
         default: begin
            rd_a_addr = pos_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         state_mem[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= state_mem[rd_a_addr];
      rd_b_ff <= state_mem[far_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= UNSEEDED_POS;
         seed_ff      <= SEED_RESET;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         if (csr_tvalid && csr_tready) begin
            seed_ff <= csr_tdata;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  if (need_seed) begin
                     prev_ff  <= seed_ff;
                     k_ff     <= index_type'(1);
                     state_ff <= ST_SEED_MUL;
                  end else if (pos_ff == DEPTH_INDEX) begin
                     k_ff     <= '0;
                     state_ff <= ST_TW_PRIME;
                  end else begin
                     state_ff <= ST_OUT;
                  end
               end
            end
            ST_SEED_MUL: begin
               prod_ff  <= word_type'(SEED_MULT * (prev_ff ^ (prev_ff >> 30)));
               state_ff <= ST_SEED_ADD;
            end
            ST_SEED_ADD: begin
               prev_ff <= seed_word;
               if (k_ff == LAST_INDEX) begin
                  k_ff     <= '0;
                  state_ff <= ST_TW_PRIME;
               end else begin
                  k_ff     <= k_ff + index_type'(1);
                  state_ff <= ST_SEED_MUL;
               end
            end
            ST_TW_PRIME: begin
               state_ff <= ST_TW_RD;
            end
            ST_TW_RD: begin
               // word 0 arrives from the priming read
               if (k_ff == '0) begin
                  cur_ff <= rd_a_ff;
               end
               state_ff <= ST_TW_WR;
            end
            ST_TW_WR: begin
               // hold the old next word as the current word of the next step
               cur_ff <= rd_a_ff;
               if (k_ff == LAST_INDEX) begin
                  pos_ff   <= '0;
                  state_ff <= ST_RD;
               end else begin
                  k_ff     <= next_idx;
                  state_ff <= ST_TW_RD;
               end
            end
            ST_RD: begin
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_data_ff  <= temper(rd_a_ff);
                  pos_ff       <= pos_ff + index_type'(1);
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- dv/tb_mersenne_twister_generator.sv -----
// ----------------------------------------------------------------------------
// tb_mersenne_twister_generator
// Self-checking testbench for the MT19937 word generator.
// ----------------------------------------------------------------------------
// Requests go in with a random restart flag, in bursts with random gaps,
// while the response side stalls in changing patterns. A scoreboard keeps its
// own 624-word generator state and seed, works out the tempered word each
// accepted request must return, and compares every response against the
// oldest pending word. The seed register is rewritten between phases, with
// zero and all-ones among the values, and one long run crosses a twist pass.
// ----------------------------------------------------------------------------
module tb_mersenne_twister_generator;
   timeunit 1ns;
   timeprecision 1ps;

   import mtg_pkg::*;

   localparam word_type HIGH_BIT    = 32'h8000_0000;
   localparam word_type LOW_BITS    = 32'h7fff_ffff;
   localparam int       STALL_LIMIT = 20000;
   localparam int       MAX_REPORTS = 10;

   class mt_word_scoreboard;
      word_type state_words[STATE_DEPTH];
      int       read_pos;
      word_type seed_reg;
      word_type pending_words[$];
      int       mismatches;
      int       words_checked;
      int       requests_seen;
      int       restarts_seen;
      int       seedings;
      int       twists;

      function new();
         read_pos = STATE_DEPTH + 1;
         seed_reg = SEED_RESET;
      endfunction

      function void load_seed(word_type value);
         seed_reg = value;
      endfunction

      function void seed_state();
         word_type prev;
         state_words[0] = seed_reg;
         for (int k = 1; k < STATE_DEPTH; k++) begin
            prev = state_words[k-1];
            state_words[k] = SEED_MULT * (prev ^ (prev >> 30)) + word_type'(k);
         end
         read_pos = STATE_DEPTH;
         seedings++;
      endfunction

      function void twist_state();
         word_type y;
         for (int k = 0; k < STATE_DEPTH; k++) begin
            y = (state_words[k] & HIGH_BIT)
              | (state_words[(k + 1) % STATE_DEPTH] & LOW_BITS);
            state_words[k] = state_words[(k + TWIST_OFFSET) % STATE_DEPTH]
                           ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : word_type'(0));
         end
         read_pos = 0;
         twists++;
      endfunction

      function word_type temper_word(word_type raw);
         word_type y;
         y = raw ^ (raw >> 11);
         y = y ^ ((y << 7) & TEMPER_B);
         y = y ^ ((y << 15) & TEMPER_C);
         return y ^ (y >> 18);
      endfunction

      function void note_request(bit restart);
         requests_seen++;
         if (restart)
            restarts_seen++;
         // the first request after reset seeds too
         if (restart || read_pos > STATE_DEPTH)
            seed_state();
         if (read_pos >= STATE_DEPTH)
            twist_state();
         pending_words.push_back(temper_word(state_words[read_pos]));
         read_pos++;
      endfunction

      function void check_word(word_type got);
         word_type want;
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%t: response %h with no request outstanding", $realtime, got);
         end else begin
            want = pending_words.pop_front();
            words_checked++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%t: random_word expected %h, got %h", $realtime, want, got);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_tvalid;
   logic        csr_tready;
   logic [31:0] csr_tdata;

   mt_word_scoreboard word_board = new();
   int  stall_cycles;
   int  seed_writes;
   bit  run_done;

   mersenne_twister_generator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         word_board.check_word(rsp_tdata);
   end

   always @(posedge clock) begin
      if (reset || run_done || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_tvalid && csr_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
         $display("mersenne_twister_generator test failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // response side: ready always, ready at random, or mostly stalled
   initial begin : rsp_stall_pattern
      int mode;
      int span;
      rsp_tready = 1'b0;
      forever begin
         mode = $urandom_range(2);
         span = $urandom_range(40, 8);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               0: begin
                  rsp_tready <= 1'b1;
               end
               1: begin
                  rsp_tready <= 1'($urandom_range(1));
               end
               default: begin
                  rsp_tready <= ($urandom_range(7) == 0);
               end
            endcase
         end
      end
   end

   // call at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input bit restart);
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, restart};
      do
         @(posedge clock);
      while (!req_tready);
      word_board.note_request(restart);
      @(negedge clock);
   endtask

   task automatic run_requests(input int count, input int restart_pct);
      int left;
      int burst;
      int gap;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(16, 1);
         if (burst > left)
            burst = left;
         repeat (burst) begin
            send_request($urandom_range(99) < restart_pct);
            left--;
         end
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic write_seed(input word_type value);
      csr_tvalid <= 1'b1;
      csr_tdata  <= value;
      do
         @(posedge clock);
      while (!csr_tready);
      word_board.load_seed(value);
      seed_writes++;
      @(negedge clock);
      csr_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain_responses();
      while (word_board.pending_words.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   initial begin : stimulus
      word_type phase_seed;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_tvalid = 1'b0;
      csr_tdata  = '0;
      run_done   = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // default seed: first plain request seeds itself, then restarts
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b1);
      send_request(1'b1);
      send_request(1'b0);
      req_tvalid <= 1'b0;
      drain_responses();

      // new seed must not matter until the next restart
      write_seed(32'h0000_0000);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b1);
      send_request(1'b0);
      req_tvalid <= 1'b0;
      drain_responses();

      write_seed(32'hffff_ffff);
      send_request(1'b1);
      send_request(1'b0);
      send_request(1'b1);
      send_request(1'b0);
      req_tvalid <= 1'b0;
      drain_responses();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            1:       phase_seed = SEED_RESET;
            3:       phase_seed = 32'h0000_0001;
            default: phase_seed = $urandom;
         endcase
         write_seed(phase_seed);
         if (phase == 2) begin
            // long plain run to cross a twist pass
            send_request(1'b1);
            run_requests(650, 0);
         end else begin
            run_requests(60, 6);
         end
         drain_responses();
      end

      repeat (16) @(posedge clock);
      run_done = 1'b1;
      $display("Checked %0d words from %0d requests, %0d with restart, %0d seed writes.",
               word_board.words_checked, word_board.requests_seen,
               word_board.restarts_seen, seed_writes);
      $display("Predicted %0d seedings and %0d twist passes; %0d mismatches.",
               word_board.seedings, word_board.twists, word_board.mismatches);
      if (word_board.mismatches == 0 && word_board.pending_words.size() == 0) begin
         $display("mersenne_twister_generator test passed");
      end else begin
         $display("mersenne_twister_generator test failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/mtg_pkg.sv
design/mersenne_twister_generator.sv
dv/tb_mersenne_twister_generator.sv
